/* hw/rtl/pwmm_pkg.sv */
// ---------------------------------------------------------------------------
// pwmm_pkg: shared constants for the PWM input period and duty meter
// Field widths, action and register codes, reset values of the registers.
// ---------------------------------------------------------------------------
package pwmm_pkg;

	// Field and datapath widths
	localparam int TIMER_W    = 16;  // capture timestamps, wrap at 2^TIMER_W
	localparam int OVF_W      = 16;  // saturating overflow counter
	localparam int TOP_W      = 16;  // counter_top register
	localparam int TPS_W      = 24;  // ticks_per_second register
	localparam int TIME_W     = 32;  // high or low time in ticks
	localparam int PERIOD_W   = TIME_W + 1;
	localparam int DUTY_NUM_W = TIME_W + 7;  // high time times the duty scale
	localparam int FREQ_W     = 24;
	localparam int DUTY_W     = 7;
	localparam int ACT_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;

	localparam logic [DUTY_W-1:0] DUTY_SCALE = 7'd100;

	// Action codes carried in the input tuser
	localparam logic [ACT_W-1:0] ACT_START    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_EDGE     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_OVERFLOW = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COUNTER_TOP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_S = 2'd1;

	// Register reset values
	localparam logic [TOP_W-1:0] COUNTER_TOP_RST = 16'd65535;
	localparam logic [TPS_W-1:0] TICKS_RST       = 24'd1000000;

endpackage

/* hw/rtl/pwmm_div.sv */
// ---------------------------------------------------------------------------
// pwmm_div: bit-serial restoring divider
// Takes one dividend bit per cycle, most significant first, and keeps the
// low QUO_W bits of the quotient. Busy stays high until all NUM_W bits are in.
// ---------------------------------------------------------------------------
module pwmm_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 33,
	parameter int QUO_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             busy,
	output logic [QUO_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W-1:0] diff;
	logic             fits;

	// Shift the next dividend bit into the partial remainder and test it;
	// when it fits the difference is below the divisor, so its low bits suffice
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = trial[DEN_W-1:0] - den_q;
		fits  = (trial >= {1'b0, den_q});
	end

	// Control: count down one step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: remainder, dividend shifter and quotient shifter
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? diff : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/pwm_input_period_duty_meter_core.sv */
// ---------------------------------------------------------------------------
// pwm_input_period_duty_meter_core: PWM period and duty meter
// Sequences capture edges and overflow ticks, then computes frequency and
// duty of one measured PWM period.
// ---------------------------------------------------------------------------
// Start, overflow and the first two capture edges are taken without stalling
// the input and produce no word. The third capture edge closes the period and
// holds the input while a bit-serial shift-add multiplier forms overflows
// times counter_top for the high and low parts, the high and low times and
// the period are summed, the period is checked for zero, and, unless it is
// zero, two bit-serial dividers work out the frequency and the duty side by
// side. The result word then sits in the output register; the input is taken
// again as soon as that register is loaded. Configuration writes are taken in
// any cycle and must only be issued while no measurement is being computed.
module pwm_input_period_duty_meter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [pwmm_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [15:0] capture_value
	input  logic [pwmm_pkg::ACT_W-1:0]          s_axis_tuser,  // [1:0] action
	// Result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [pwmm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [23:0] frequency_hz,
	                                                           // [30:24] duty_percent,
	                                                           // [31] zero pad
	output logic                                m_axis_tuser,  // [0] zero_period_error
	// Configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pwmm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pwmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int TW  = pwmm_pkg::TIMER_W;
	localparam int OW  = pwmm_pkg::OVF_W;
	localparam int TMW = pwmm_pkg::TIME_W;
	localparam int PW  = pwmm_pkg::PERIOD_W;
	localparam int NW  = pwmm_pkg::DUTY_NUM_W;
	localparam int MCW = $clog2(OW);

	// Measurement phases
	localparam logic [1:0] PH_RISE  = 2'd0;
	localparam logic [1:0] PH_FALL  = 2'd1;
	localparam logic [1:0] PH_CLOSE = 2'd2;
	localparam logic [1:0] PH_IDLE  = 2'd3;

	// Sequencer states
	localparam logic [2:0] ST_IN  = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_SUM = 3'd2;
	localparam logic [2:0] ST_PER = 3'd3;
	localparam logic [2:0] ST_CHK = 3'd4;
	localparam logic [2:0] ST_DIV = 3'd5;
	localparam logic [2:0] ST_OUT = 3'd6;

	logic [2:0]                   state_q;
	logic [1:0]                   phase_q;
	logic [pwmm_pkg::TOP_W-1:0]   counter_top_q;
	logic [pwmm_pkg::TPS_W-1:0]   ticks_q;
	logic [TW-1:0]                rise_q;
	logic [TW-1:0]                fall_q;
	logic [OW-1:0]                ovf_q;
	logic [OW-1:0]                high_ovf_q;

	logic [TMW-1:0]               mcand_q;
	logic [OW-1:0]                hi_mplier_q;
	logic [OW-1:0]                lo_mplier_q;
	logic [TMW-1:0]               hi_acc_q;
	logic [TMW-1:0]               lo_acc_q;
	logic [MCW-1:0]               mul_cnt_q;
	logic [TW-1:0]                hi_diff_q;
	logic [TW-1:0]                lo_diff_q;
	logic [TMW-1:0]               high_q;
	logic [TMW-1:0]               low_q;
	logic [PW-1:0]                period_q;
	logic [NW-1:0]                duty_num_q;

	logic [pwmm_pkg::FREQ_W-1:0]  res_freq_q;
	logic [pwmm_pkg::DUTY_W-1:0]  res_duty_q;
	logic                         res_err_q;

	logic                         out_valid_q;
	logic [pwmm_pkg::FREQ_W-1:0]  out_freq_q;
	logic [pwmm_pkg::DUTY_W-1:0]  out_duty_q;
	logic                         out_err_q;

	logic                         in_fire;
	logic                         div_start;
	logic                         freq_busy;
	logic                         duty_busy;
	logic [pwmm_pkg::FREQ_W-1:0]  freq_quo;
	logic [pwmm_pkg::DUTY_W-1:0]  duty_quo;
	logic                         out_free;
	logic                         close_edge;

	assign s_axis_tready = (state_q == ST_IN);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign div_start     = (state_q == ST_CHK) && (period_q != '0);
	assign close_edge    = in_fire && (s_axis_tuser == pwmm_pkg::ACT_EDGE) &&
	                       (phase_q == PH_CLOSE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_top_q <= pwmm_pkg::COUNTER_TOP_RST;
			ticks_q       <= pwmm_pkg::TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pwmm_pkg::REG_COUNTER_TOP: counter_top_q <= cfg_data[pwmm_pkg::TOP_W-1:0];
				pwmm_pkg::REG_TICKS_PER_S: ticks_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Edge sequencer: phase, timestamps and overflow counting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			rise_q     <= '0;
			fall_q     <= '0;
			ovf_q      <= '0;
			high_ovf_q <= '0;
		end else if (in_fire) begin
			case (s_axis_tuser)
				pwmm_pkg::ACT_START: begin
					phase_q <= PH_RISE;
					ovf_q   <= '0;
				end
				pwmm_pkg::ACT_OVERFLOW: begin
					if (phase_q != PH_IDLE && ovf_q != '1) begin
						ovf_q <= ovf_q + 1'b1;
					end
				end
				pwmm_pkg::ACT_EDGE: begin
					case (phase_q)
						PH_RISE: begin
							rise_q  <= s_axis_tdata[TW-1:0];
							ovf_q   <= '0;
							phase_q <= PH_FALL;
						end
						PH_FALL: begin
							fall_q     <= s_axis_tdata[TW-1:0];
							high_ovf_q <= ovf_q;
							ovf_q      <= '0;
							phase_q    <= PH_CLOSE;
						end
						PH_CLOSE: phase_q <= PH_IDLE;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Compute sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IN;
			mul_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IN: begin
					if (close_edge) begin
						state_q   <= ST_MUL;
						mul_cnt_q <= '0;
					end
				end
				ST_MUL: begin
					mul_cnt_q <= mul_cnt_q + 1'b1;
					if (mul_cnt_q == MCW'(OW - 1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: state_q <= ST_PER;
				ST_PER: state_q <= ST_CHK;
				ST_CHK: state_q <= (period_q == '0) ? ST_OUT : ST_DIV;
				ST_DIV: begin
					if (!freq_busy && !duty_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IN;
					end
				end
				default: state_q <= ST_IN;
			endcase
		end
	end

	// Datapath: shift-add products, part times, period and duty numerator
	always_ff @(posedge clk) begin
		if (close_edge) begin
			mcand_q     <= TMW'(counter_top_q);
			hi_mplier_q <= high_ovf_q;
			lo_mplier_q <= ovf_q;
			hi_acc_q    <= '0;
			lo_acc_q    <= '0;
			hi_diff_q   <= fall_q - rise_q;
			lo_diff_q   <= s_axis_tdata[TW-1:0] - fall_q;
		end
		if (state_q == ST_MUL) begin
			if (hi_mplier_q[0]) begin
				hi_acc_q <= hi_acc_q + mcand_q;
			end
			if (lo_mplier_q[0]) begin
				lo_acc_q <= lo_acc_q + mcand_q;
			end
			mcand_q     <= {mcand_q[TMW-2:0], 1'b0};
			hi_mplier_q <= {1'b0, hi_mplier_q[OW-1:1]};
			lo_mplier_q <= {1'b0, lo_mplier_q[OW-1:1]};
		end
		if (state_q == ST_SUM) begin
			high_q <= hi_acc_q + TMW'(hi_diff_q);
			low_q  <= lo_acc_q + TMW'(lo_diff_q);
		end
		if (state_q == ST_PER) begin
			period_q   <= PW'(high_q) + PW'(low_q);
			duty_num_q <= NW'(high_q) * NW'(pwmm_pkg::DUTY_SCALE);
		end
		// Collect the result: zero period, or the divider quotients
		if (state_q == ST_CHK && period_q == '0) begin
			res_freq_q <= '0;
			res_duty_q <= '0;
			res_err_q  <= 1'b1;
		end
		if (state_q == ST_DIV && !freq_busy && !duty_busy) begin
			res_freq_q <= freq_quo;
			res_duty_q <= duty_quo;
			res_err_q  <= 1'b0;
		end
	end

	// Frequency: ticks per second over the period
	pwmm_div #(
		.NUM_W (pwmm_pkg::TPS_W),
		.DEN_W (PW),
		.QUO_W (pwmm_pkg::FREQ_W)
	) u_freq_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (ticks_q),
		.denom    (period_q),
		.busy     (freq_busy),
		.quotient (freq_quo)
	);

	// Duty: high time times the scale over the period
	pwmm_div #(
		.NUM_W (NW),
		.DEN_W (PW),
		.QUO_W (pwmm_pkg::DUTY_W)
	) u_duty_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (duty_num_q),
		.denom    (period_q),
		.busy     (duty_busy),
		.quotient (duty_quo)
	);

	// Output register: load in the output state, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_freq_q <= res_freq_q;
			out_duty_q <= res_duty_q;
			out_err_q  <= res_err_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_duty_q, out_freq_q};
	assign m_axis_tuser  = out_err_q;

endmodule

/* hw/rtl/pwmm_checker.sv */
// ---------------------------------------------------------------------------
// pwmm_checker: port-level checks for the PWM period and duty meter
// Watches the top-level ports only; attached to the core by bind.
// ---------------------------------------------------------------------------
module pwmm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [pwmm_pkg::ACT_W-1:0]       s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [pwmm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic                             m_axis_tuser
);

	// Hold a result word until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped before it was taken");

	// A fresh result word only follows a busy compute, with the input stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result word appeared without a compute phase");

	// Start and overflow words never stall the input
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready &&
		(s_axis_tuser == pwmm_pkg::ACT_START || s_axis_tuser == pwmm_pkg::ACT_OVERFLOW)
		|=> s_axis_tready)
		else $error("input stalled after a start or overflow word");

	// A zero period clears both result fields
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("zero period word carries nonzero fields");

	// Duty never exceeds the scale
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[30:24] <= pwmm_pkg::DUTY_SCALE)
		else $error("duty above full scale");

endmodule

bind pwm_input_period_duty_meter_core pwmm_checker u_pwmm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
